### rtl/bpc_pkg.sv
// Types and constants shared by the button press classifier.
package bpc_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned CFG_IDX_WIDTH = 2;
    localparam int unsigned TS_WIDTH = 32;
    localparam int unsigned TAP_WIDTH = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS = 2'd2;

    // Configuration reset values
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_WINDOW_RST = 16'd250;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd2000;

    // Input action codes
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_MULTI = 2'd2;
    localparam logic [1:0] EV_LONG = 2'd3;

    localparam logic [TAP_WIDTH-1:0] TAP_MAX = 8'd255;

    typedef struct packed {
        logic                action;
        logic [TS_WIDTH-1:0] time_ms;
        logic                button_down;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           event_res;
        logic [TAP_WIDTH-1:0] tap_count;
        logic                 is_held;
    } t_out_item;

endpackage

### rtl/button_press_classifier_core.sv
// Pipeline from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while the output is not stalled by i_ready; set by
// the single compare-and-update pass on the classifier state between the two registers.
// Reset: synchronous, active low; clears the pipeline valids, the classifier state and loads
// the configuration defaults (debounce 50, double window 250, long press 2000).
module button_press_classifier_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  bpc_pkg::t_in_item       i_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output bpc_pkg::t_out_item      o_out,
    input  logic                    i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]     i_cfg_wdata
);
    import bpc_pkg::*;

    localparam int unsigned EXT_WIDTH = (TIME_WIDTH > TS_WIDTH) ? TIME_WIDTH : TS_WIDTH;

    // Configuration
    logic [CFG_WIDTH-1:0] r_debounce;
    logic [CFG_WIDTH-1:0] r_double_window;
    logic [CFG_WIDTH-1:0] r_long_press;

    // Pipeline
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_advance;

    // Classifier state
    logic                  r_held,     n_held;
    logic [TIME_WIDTH-1:0] r_last_chg, n_last_chg;
    logic [TIME_WIDTH-1:0] r_press_st, n_press_st;
    logic [TIME_WIDTH-1:0] r_release,  n_release;
    logic [TAP_WIDTH-1:0]  r_taps,     n_taps;
    logic                  r_win_open, n_win_open;
    logic                  r_long_done, n_long_done;
    t_out_item             n_out;

    logic [EXT_WIDTH-1:0]  w_t_ext;
    logic [TIME_WIDTH-1:0] w_t;
    logic [TIME_WIDTH-1:0] w_since_chg;
    logic [TIME_WIDTH-1:0] w_since_press;
    logic [TIME_WIDTH-1:0] w_since_rel;
    logic                  w_fire_long;

    assign w_advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !r_in_vld || w_advance;
    assign o_valid   = r_out_vld;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce      <= DEBOUNCE_RST;
            r_double_window <= DOUBLE_WINDOW_RST;
            r_long_press    <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:      r_debounce      <= i_cfg_wdata;
                CFG_DOUBLE_WINDOW: r_double_window <= i_cfg_wdata;
                CFG_LONG_PRESS:    r_long_press    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
    end

    // The timestamp is cut or zero-extended to the internal time width.
    assign w_t_ext       = EXT_WIDTH'(r_in.time_ms);
    assign w_t           = w_t_ext[TIME_WIDTH-1:0];
    assign w_since_chg   = w_t - r_last_chg;
    assign w_since_press = w_t - r_press_st;
    assign w_since_rel   = w_t - r_release;

    assign w_fire_long = r_held && !r_long_done &&
                         (w_since_press >= TIME_WIDTH'(r_long_press));

    always_comb begin
        n_held      = r_held;
        n_last_chg  = r_last_chg;
        n_press_st  = r_press_st;
        n_release   = r_release;
        n_taps      = r_taps;
        n_win_open  = r_win_open;
        n_long_done = r_long_done;
        n_out.event_res = EV_NONE;
        n_out.tap_count = '0;

        if (r_in.action == ACT_EDGE) begin
            if ((r_in.button_down != r_held) &&
                (w_since_chg > TIME_WIDTH'(r_debounce))) begin
                n_last_chg = w_t;
                n_held     = r_in.button_down;
                if (r_in.button_down) begin
                    n_press_st  = w_t;
                    n_long_done = 1'b0;
                end else begin
                    n_release = w_t;
                    // A release that ended a long press is not a tap.
                    if (!r_long_done) begin
                        if (r_taps != TAP_MAX) begin
                            n_taps = r_taps + 1'b1;
                        end
                        n_win_open = 1'b1;
                    end
                end
            end
        end else begin
            if (w_fire_long) begin
                n_long_done     = 1'b1;
                n_win_open      = 1'b0;
                n_taps          = '0;
                n_out.event_res = EV_LONG;
            end else if (r_win_open && (w_since_rel > TIME_WIDTH'(r_double_window))) begin
                n_win_open = 1'b0;
                n_taps     = '0;
                if (r_taps == TAP_WIDTH'(1)) begin
                    n_out.event_res = EV_SINGLE;
                    n_out.tap_count = r_taps;
                end else if (r_taps != '0) begin
                    n_out.event_res = EV_MULTI;
                    n_out.tap_count = r_taps;
                end
            end
        end
        n_out.is_held = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_last_chg  <= '0;
            r_press_st  <= '0;
            r_release   <= '0;
            r_taps      <= '0;
            r_win_open  <= 1'b0;
            r_long_done <= 1'b0;
        end else if (w_advance) begin
            r_held      <= n_held;
            r_last_chg  <= n_last_chg;
            r_press_st  <= n_press_st;
            r_release   <= n_release;
            r_taps      <= n_taps;
            r_win_open  <= n_win_open;
            r_long_done <= n_long_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // A long press is only reported while the button is held and carries no tap count.
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.event_res == EV_LONG) |-> (r_out.is_held && r_out.tap_count == '0))
        else $error("long press reported without held button or with taps");

    // Tap count agrees with the reported event kind.
    a_tap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.event_res == EV_SINGLE) |-> (r_out.tap_count == TAP_WIDTH'(1)))
        else $error("single press with wrong tap count");

    a_multi_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.event_res == EV_MULTI) |-> (r_out.tap_count > TAP_WIDTH'(1)))
        else $error("multi press with fewer than two taps");

    // After a press event is reported, the tap counter and window are cleared.
    a_taps_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out.event_res != EV_NONE) |=> (r_taps == '0 && !r_win_open))
        else $error("taps or window not cleared after event");
`endif

endmodule
